// File: rtl/sva_pkg.sv
// Shared types, constants and helpers for the voice allocator.
`timescale 1ns / 1ps
`default_nettype none

package sva_pkg;

    localparam int SVA_FUNC_W   = 2;
    localparam int SVA_CH_W     = 6;
    localparam int SVA_VIN_W    = 4;
    localparam int SVA_VOUT_W   = 4;
    localparam int SVA_VOICES   = 16;
    localparam int SVA_CHANNELS = 64;
    localparam int SVA_LFSR_W   = 16;
    localparam logic [SVA_LFSR_W-1:0] SVA_LFSR_SEED = 16'hACE1;

    typedef enum logic [SVA_FUNC_W-1:0] {
        FUNC_LOOKUP  = 2'd0,
        FUNC_ALLOC   = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_CLEAR   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REL
    } t_state;

    // Fibonacci x^16+x^14+x^13+x^11+1, shifting right, feedback into the MSB
    function automatic logic [SVA_LFSR_W-1:0] sva_lfsr_next(input logic [SVA_LFSR_W-1:0] s);
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[SVA_LFSR_W-1:1]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/sva_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/sva_voice_search.sv
// Free-voice search: first free voice at or above channel mod VOICES, else first free overall.
`timescale 1ns / 1ps
`default_nettype none

module sva_voice_search
    import sva_pkg::*;
#(
    parameter int VOICES = SVA_VOICES,
    localparam int VW    = $clog2(VOICES)
) (
    input  wire logic [VOICES-1:0]   i_owned,
    input  wire logic [SVA_CH_W-1:0] i_channel,
    output logic                     o_hit,
    output logic      [VW-1:0]       o_idx
);

    localparam int NCH = 1 << SVA_CH_W;

    logic [VW-1:0]     w_start_tab [NCH];
    logic [VW-1:0]     w_start;
    logic [VOICES-1:0] w_free;
    logic [VOICES-1:0] w_upper;
    logic              w_hit_up;
    logic              w_hit_any;
    logic [VW-1:0]     w_idx_up;
    logic [VW-1:0]     w_idx_any;

    // start point table, channel mod VOICES, fixed at elaboration
    for (genvar c = 0; c < NCH; c++) begin : g_start
        assign w_start_tab[c] = VW'(c % VOICES);
    end

    assign w_start = w_start_tab[i_channel];
    assign w_free  = ~i_owned;

    always_comb begin
        for (int k = 0; k < VOICES; k++) begin
            w_upper[k] = w_free[k] && (VW'(k) >= w_start);
        end
    end

    // lowest set bit wins
    always_comb begin
        w_hit_up  = 1'b0;
        w_hit_any = 1'b0;
        w_idx_up  = '0;
        w_idx_any = '0;
        for (int k = VOICES - 1; k >= 0; k--) begin
            if (w_upper[k]) begin
                w_hit_up = 1'b1;
                w_idx_up = VW'(k);
            end
            if (w_free[k]) begin
                w_hit_any = 1'b1;
                w_idx_any = VW'(k);
            end
        end
    end

    assign o_hit = w_hit_any;
    assign o_idx = w_hit_up ? w_idx_up : w_idx_any;

endmodule

`default_nettype wire

// File: rtl/synth_voice_allocator_unit.sv
// Voice allocator top: command FSM, channel map and voice owner memories, steal LFSR.
// Sequence: lookup, allocate and clear pass from IDLE to EXEC and register their result
// from EXEC; release of an owned voice adds REL (owner read, then map read of that owner).
// A new transaction is taken only in IDLE, so one completes before the next; busy covers the
// memory read-modify-write sequence. Results are single-cycle strobes on o_valid.
// Reset (synchronous, active low) clears all map and owner valid bits at once and
// seeds the LFSR with 0xACE1; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module synth_voice_allocator_unit
    import sva_pkg::*;
#(
    parameter int VOICES   = SVA_VOICES,
    parameter int CHANNELS = SVA_CHANNELS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [SVA_FUNC_W-1:0] i_func,
    input  wire logic [SVA_CH_W-1:0]   i_channel,
    input  wire logic [SVA_VIN_W-1:0]  i_voice,
    output logic                       o_valid,
    output logic                       o_found,
    output logic      [SVA_VOUT_W-1:0] o_voice_out,
    output logic                       o_stolen
);

    localparam int VW = $clog2(VOICES);
    localparam int MW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_state                  r_state, n_state;
    t_func                   r_func, n_func;
    logic [SVA_CH_W-1:0]     r_channel, n_channel;
    logic [SVA_VIN_W-1:0]    r_voice, n_voice;
    logic [CHANNELS-1:0]     r_map_valid, n_map_valid;
    logic [VOICES-1:0]       r_owner_valid, n_owner_valid;
    logic [SVA_LFSR_W-1:0]   r_lfsr, n_lfsr;
    logic                    r_valid, n_valid;
    logic                    r_found, n_found;
    logic [SVA_VOUT_W-1:0]   r_voice_out, n_voice_out;
    logic                    r_stolen, n_stolen;

    logic                    w_ch_ok;
    logic                    w_v_ok;
    logic [MW-1:0]           w_ch_idx;
    logic [VW-1:0]           w_v_idx;
    logic [MW-1:0]           w_oc_idx;
    logic                    w_hit;
    logic [VW-1:0]           w_free_idx;
    logic [SVA_LFSR_W-1:0]   w_lfsr_step;
    logic [31:0]             w_prod;
    logic [VW-1:0]           w_steal_idx;
    logic [VW-1:0]           w_alloc_idx;

    logic                    w_map_we;
    logic [MW-1:0]           w_map_raddr;
    logic [VW-1:0]           w_map_rdata;
    logic                    w_own_we;
    logic [VW-1:0]           w_own_raddr;
    logic [SVA_CH_W-1:0]     w_own_rdata;

    assign w_ch_ok  = (32'(r_channel) < CHANNELS);
    assign w_v_ok   = (32'(r_voice) < VOICES);
    assign w_ch_idx = MW'(r_channel);
    assign w_v_idx  = VW'(r_voice);
    assign w_oc_idx = MW'(w_own_rdata);

    // steal pick: (next lfsr * VOICES) >> 16
    assign w_lfsr_step = sva_lfsr_next(r_lfsr);
    assign w_prod      = 32'(w_lfsr_step) * 32'(VOICES);
    assign w_steal_idx = w_prod[SVA_LFSR_W +: VW];
    assign w_alloc_idx = w_hit ? w_free_idx : w_steal_idx;

    // map read: channel at accept, owner's channel during a release
    assign w_map_raddr = (r_state == ST_IDLE) ? MW'(i_channel) : w_oc_idx;
    assign w_own_raddr = (r_state == ST_IDLE) ? VW'(i_voice) : w_v_idx;

    sva_voice_search #(
        .VOICES (VOICES)
    ) u_search (
        .i_owned   (r_owner_valid),
        .i_channel (r_channel),
        .o_hit     (w_hit),
        .o_idx     (w_free_idx)
    );

    sva_ram #(
        .WIDTH (VW),
        .DEPTH (CHANNELS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_ch_idx),
        .i_wdata (w_alloc_idx),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rdata)
    );

    sva_ram #(
        .WIDTH (SVA_CH_W),
        .DEPTH (VOICES)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (w_own_we),
        .i_waddr (w_alloc_idx),
        .i_wdata (r_channel),
        .i_raddr (w_own_raddr),
        .o_rdata (w_own_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_valid   <= '0;
            r_owner_valid <= '0;
            r_lfsr        <= SVA_LFSR_SEED;
            r_valid       <= 1'b0;
        end else begin
            r_map_valid   <= n_map_valid;
            r_owner_valid <= n_owner_valid;
            r_lfsr        <= n_lfsr;
            r_valid       <= n_valid;
        end
        r_func      <= n_func;
        r_channel   <= n_channel;
        r_voice     <= n_voice;
        r_found     <= n_found;
        r_voice_out <= n_voice_out;
        r_stolen    <= n_stolen;
    end

    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_channel     = r_channel;
        n_voice       = r_voice;
        n_map_valid   = r_map_valid;
        n_owner_valid = r_owner_valid;
        n_lfsr        = r_lfsr;
        n_valid       = 1'b0;
        n_found       = r_found;
        n_voice_out   = r_voice_out;
        n_stolen      = r_stolen;
        w_map_we      = 1'b0;
        w_own_we      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_func    = t_func'(i_func);
                    n_channel = i_channel;
                    n_voice   = i_voice;
                    n_state   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_found     = 1'b0;
                n_voice_out = '0;
                n_stolen    = 1'b0;
                unique case (r_func)
                    FUNC_LOOKUP: begin
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                        if (w_ch_ok && r_map_valid[w_ch_idx]) begin
                            n_found     = 1'b1;
                            n_voice_out = SVA_VOUT_W'(w_map_rdata);
                        end
                    end
                    FUNC_ALLOC: begin
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                        if (w_ch_ok) begin
                            w_map_we                   = 1'b1;
                            w_own_we                   = 1'b1;
                            n_map_valid[w_ch_idx]      = 1'b1;
                            n_owner_valid[w_alloc_idx] = 1'b1;
                            n_found                    = 1'b1;
                            n_voice_out                = SVA_VOUT_W'(w_alloc_idx);
                            if (!w_hit) begin
                                n_lfsr   = w_lfsr_step;
                                n_stolen = 1'b1;
                            end
                        end
                    end
                    FUNC_RELEASE: begin
                        if (w_v_ok && r_owner_valid[w_v_idx]) begin
                            n_state = ST_REL;
                        end else begin
                            n_valid = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                    FUNC_CLEAR: begin
                        n_valid     = 1'b1;
                        n_state     = ST_IDLE;
                        n_map_valid = '0;
                    end
                endcase
            end
            ST_REL: begin
                // owner's map entry is dropped only if it still points here
                n_valid     = 1'b1;
                n_state     = ST_IDLE;
                n_found     = 1'b1;
                n_voice_out = '0;
                n_stolen    = 1'b0;
                if (r_map_valid[w_oc_idx] && (w_map_rdata == w_v_idx)) begin
                    n_map_valid[w_oc_idx] = 1'b0;
                end
                n_owner_valid[w_v_idx] = 1'b0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_found     = r_found;
    assign o_voice_out = r_voice_out;
    assign o_stolen    = r_stolen;

    // an accepted transaction always occupies the block on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // a steal only happens with every voice owned, and counts as found
    a_steal_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stolen) |-> (o_found && (&r_owner_valid)))
        else $error("steal reported while a voice was free");

    // result strobe only follows a busy cycle
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a transaction in flight");

    // release state only follows the execute state
    a_rel_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REL) |-> ($past(r_state) == ST_EXEC))
        else $error("release step entered out of sequence");

endmodule

`default_nettype wire
